/* hw/rtl/wsc_pkg.sv */
// Shared types and constants for the wire segment crossing block.
`timescale 1ns / 1ps
`default_nettype none

package wsc_pkg;

  localparam int CoordBits  = 24;
  localparam int ChanBits   = 20;
  localparam int TpcBits    = 8;
  localparam int PlaneBits  = 2;
  localparam int LimitBits  = 24;
  localparam logic [LimitBits-1:0] LimitReset = LimitBits'(7);

  localparam int DirBits  = CoordBits + 1;   // endpoint differences
  localparam int ProdBits = 2 * DirBits;     // one cross-product term
  localparam int DiffBits = ProdBits + 1;    // det, d1, d2 (signed)
  localparam int MagBits  = ProdBits;        // their magnitudes
  localparam int RemBits  = MagBits + 2;     // divider partial remainder

  typedef enum logic [2:0] {
    ST_CROSS      = 3'd0,
    ST_SAME_CHAN  = 3'd1,
    ST_OTHER_TPC  = 3'd2,
    ST_SAME_PLANE = 3'd3,
    ST_PARALLEL   = 3'd4,
    ST_OUTSIDE    = 3'd5
  } status_e;

  typedef struct packed {
    logic                        mode;
    logic [ChanBits-1:0]         channel;
    logic [TpcBits-1:0]          tpc;
    logic [PlaneBits-1:0]        plane;
    logic signed [CoordBits-1:0] end1_x;
    logic signed [CoordBits-1:0] end1_y;
    logic signed [CoordBits-1:0] end2_x;
    logic signed [CoordBits-1:0] end2_y;
  } wsc_in_t;

  typedef struct packed {
    status_e                     status;
    logic [ChanBits-1:0]         tested_channel;
    logic signed [CoordBits-1:0] cross_x;
    logic signed [CoordBits-1:0] cross_y;
  } wsc_out_t;

endpackage

`default_nettype wire

/* hw/rtl/wsc_div.sv */
// Pipelined rounded quotient round(num * mul / den), one multiplier bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module wsc_div import wsc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [MagBits-1:0] num_i,
  input  wire logic [MagBits-1:0] den_i,
  input  wire logic [DirBits-1:0] mul_i,
  output logic      [DirBits-1:0] quo_o
);

  logic [RemBits-1:0] rem_q [DirBits];
  logic [DirBits-1:0] quo_q [DirBits];
  logic [MagBits-1:0] num_q [DirBits];
  logic [MagBits-1:0] den_q [DirBits];
  logic [DirBits-1:0] mul_q [DirBits];

  for (genvar k = 0; k < DirBits; k++) begin : g_stage
    logic [RemBits-1:0] rem_in, acc, den_x, den_x2, rem_d;
    logic [DirBits-1:0] quo_in, quo_d;
    logic [MagBits-1:0] num_in, den_in;
    logic [DirBits-1:0] mul_in;
    logic [1:0]         digit;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = num_i;
      assign den_in = den_i;
      assign mul_in = mul_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign mul_in = mul_q[k-1];
    end

    // Quotient digit is 0, 1 or 2 as long as num does not exceed den.
    always_comb begin
      den_x  = {2'b00, den_in};
      den_x2 = {1'b0, den_in, 1'b0};
      acc    = {rem_in[RemBits-2:0], 1'b0} +
               (mul_in[DirBits-1-k] ? {2'b00, num_in} : '0);
      if (acc >= den_x2) begin
        rem_d = acc - den_x2;
        digit = 2'd2;
      end else if (acc >= den_x) begin
        rem_d = acc - den_x;
        digit = 2'd1;
      end else begin
        rem_d = acc;
        digit = 2'd0;
      end
      quo_d = {quo_in[DirBits-2:0], 1'b0} + {{(DirBits-2){1'b0}}, digit};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        quo_q[k] <= quo_d;
        num_q[k] <= num_in;
        den_q[k] <= den_in;
        mul_q[k] <= mul_in;
      end
    end
  end

  // Round to nearest, ties up.
  always_comb begin
    if ({rem_q[DirBits-1][RemBits-2:0], 1'b0} >= {2'b00, den_q[DirBits-1]}) begin
      quo_o = quo_q[DirBits-1] + DirBits'(1);
    end else begin
      quo_o = quo_q[DirBits-1];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/wire_segment_crossing.sv */
// Top level of the wire segment crossing block.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-----------
//  in       | input     | in_valid_i/in_ready_o   | wsc_in_t
//  out      | output    | out_valid_o/out_ready_i | wsc_out_t
//  cfg      | input     | cfg_we_i            | cfg_data_i (parallel limit)
//
// One transaction per cycle while the output is not stalled. A test passes through
// four arithmetic stages, one divider stage per direction bit and the output register.
// Loads update the reference at accept and give no result.
// Reset clears the reference to zero and the limit to 7; no clearing pass.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module wire_segment_crossing import wsc_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire wsc_in_t              in_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output wsc_out_t                  out_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [LimitBits-1:0] cfg_data_i
);

  localparam int Depth = DirBits;

  logic en, in_acc;
  assign en         = !(out_valid_o && !out_ready_i);
  assign in_ready_o = en;
  assign in_acc     = in_valid_i && in_ready_o;

  // Configuration and reference wire
  logic [LimitBits-1:0]        lim_q;
  logic [ChanBits-1:0]         ref_chan_q;
  logic [TpcBits-1:0]          ref_tpc_q;
  logic [PlaneBits-1:0]        ref_plane_q;
  logic signed [CoordBits-1:0] ref_px_q, ref_py_q;
  logic signed [DirBits-1:0]   ref_rx_q, ref_ry_q;

  logic signed [DirBits-1:0] e1x, e1y, e2x, e2y, sx_w, sy_w;
  assign e1x  = {in_i.end1_x[CoordBits-1], in_i.end1_x};
  assign e1y  = {in_i.end1_y[CoordBits-1], in_i.end1_y};
  assign e2x  = {in_i.end2_x[CoordBits-1], in_i.end2_x};
  assign e2y  = {in_i.end2_y[CoordBits-1], in_i.end2_y};
  assign sx_w = e2x - e1x;
  assign sy_w = e2y - e1y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q       <= LimitReset;
      ref_chan_q  <= '0;
      ref_tpc_q   <= '0;
      ref_plane_q <= '0;
      ref_px_q    <= '0;
      ref_py_q    <= '0;
      ref_rx_q    <= '0;
      ref_ry_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        lim_q <= cfg_data_i;
      end
      if (in_acc && !in_i.mode) begin
        ref_chan_q  <= in_i.channel;
        ref_tpc_q   <= in_i.tpc;
        ref_plane_q <= in_i.plane;
        ref_px_q    <= in_i.end1_x;
        ref_py_q    <= in_i.end1_y;
        ref_rx_q    <= sx_w;
        ref_ry_q    <= sy_w;
      end
    end
  end

  // Stage 1: identity checks and differences
  status_e early_w;
  always_comb begin
    if (in_i.channel == ref_chan_q) begin
      early_w = ST_SAME_CHAN;
    end else if (in_i.tpc != ref_tpc_q) begin
      early_w = ST_OTHER_TPC;
    end else if (in_i.plane == ref_plane_q) begin
      early_w = ST_SAME_PLANE;
    end else begin
      early_w = ST_CROSS;
    end
  end

  logic                        v1_q, v2_q, v3_q, v4_q;
  status_e                     st1_q, st2_q, st3_q, st4_q;
  logic [ChanBits-1:0]         ch1_q, ch2_q, ch3_q, ch4_q;
  logic signed [CoordBits-1:0] px1_q, py1_q, px2_q, py2_q, px3_q, py3_q, px4_q, py4_q;
  logic signed [DirBits-1:0]   rx1_q, ry1_q, sx1_q, sy1_q, dx1_q, dy1_q;
  logic signed [DirBits-1:0]   rx2_q, ry2_q, rx3_q, ry3_q;
  logic signed [ProdBits-1:0]  p_rs_q, p_ys_q, p_d1a_q, p_d1b_q, p_d2a_q, p_d2b_q;
  logic signed [DiffBits-1:0]  det3_q, d13_q, d23_q;
  logic [MagBits-1:0]          det4_q, d14_q;
  logic [DirBits-1:0]          mx4_q, my4_q;
  logic                        sgx4_q, sgy4_q;

  // Stage 4 combinational: orient det positive, classify
  logic signed [DiffBits-1:0] detn, d1n, d2n;
  status_e                    st4_d;
  always_comb begin
    if (det3_q[DiffBits-1]) begin
      detn = -det3_q;
      d1n  = -d13_q;
      d2n  = -d23_q;
    end else begin
      detn = det3_q;
      d1n  = d13_q;
      d2n  = d23_q;
    end
    if (st3_q != ST_CROSS) begin
      st4_d = st3_q;
    end else if (detn == '0 || detn < $signed({{(DiffBits-LimitBits){1'b0}}, lim_q})) begin
      st4_d = ST_PARALLEL;
    end else if (d1n[DiffBits-1] || d1n > detn || d2n[DiffBits-1] || d2n > detn) begin
      st4_d = ST_OUTSIDE;
    end else begin
      st4_d = ST_CROSS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_acc && in_i.mode;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st1_q <= early_w;
      ch1_q <= in_i.channel;
      px1_q <= ref_px_q;
      py1_q <= ref_py_q;
      rx1_q <= ref_rx_q;
      ry1_q <= ref_ry_q;
      sx1_q <= sx_w;
      sy1_q <= sy_w;
      dx1_q <= e1x - {ref_px_q[CoordBits-1], ref_px_q};
      dy1_q <= e1y - {ref_py_q[CoordBits-1], ref_py_q};
      // Stage 2: cross-product terms
      st2_q   <= st1_q;
      ch2_q   <= ch1_q;
      px2_q   <= px1_q;
      py2_q   <= py1_q;
      rx2_q   <= rx1_q;
      ry2_q   <= ry1_q;
      p_rs_q  <= rx1_q * sy1_q;
      p_ys_q  <= ry1_q * sx1_q;
      p_d1a_q <= dx1_q * sy1_q;
      p_d1b_q <= dy1_q * sx1_q;
      p_d2a_q <= dx1_q * ry1_q;
      p_d2b_q <= dy1_q * rx1_q;
      // Stage 3: determinants
      st3_q  <= st2_q;
      ch3_q  <= ch2_q;
      px3_q  <= px2_q;
      py3_q  <= py2_q;
      rx3_q  <= rx2_q;
      ry3_q  <= ry2_q;
      det3_q <= DiffBits'(p_rs_q) - DiffBits'(p_ys_q);
      d13_q  <= DiffBits'(p_d1a_q) - DiffBits'(p_d1b_q);
      d23_q  <= DiffBits'(p_d2a_q) - DiffBits'(p_d2b_q);
      // Stage 4: classification and magnitudes
      st4_q  <= st4_d;
      ch4_q  <= ch3_q;
      px4_q  <= px3_q;
      py4_q  <= py3_q;
      det4_q <= detn[MagBits-1:0];
      d14_q  <= d1n[MagBits-1:0];
      sgx4_q <= rx3_q[DirBits-1];
      sgy4_q <= ry3_q[DirBits-1];
      mx4_q  <= rx3_q[DirBits-1] ? DirBits'(-rx3_q) : DirBits'(rx3_q);
      my4_q  <= ry3_q[DirBits-1] ? DirBits'(-ry3_q) : DirBits'(ry3_q);
    end
  end

  // Divider pipelines for the two offsets
  logic [DirBits-1:0] offx, offy;

  wsc_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (d14_q),
    .den_i (det4_q),
    .mul_i (mx4_q),
    .quo_o (offx)
  );

  wsc_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (d14_q),
    .den_i (det4_q),
    .mul_i (my4_q),
    .quo_o (offy)
  );

  // Side payload travelling alongside the dividers
  logic                        pv_q  [Depth];
  status_e                     pst_q [Depth];
  logic [ChanBits-1:0]         pch_q [Depth];
  logic signed [CoordBits-1:0] ppx_q [Depth];
  logic signed [CoordBits-1:0] ppy_q [Depth];
  logic                        psx_q [Depth];
  logic                        psy_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        pv_q[i] <= 1'b0;
      end
    end else if (en) begin
      pv_q[0] <= v4_q;
      for (int i = 1; i < Depth; i++) begin
        pv_q[i] <= pv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pst_q[0] <= st4_q;
      pch_q[0] <= ch4_q;
      ppx_q[0] <= px4_q;
      ppy_q[0] <= py4_q;
      psx_q[0] <= sgx4_q;
      psy_q[0] <= sgy4_q;
      for (int i = 1; i < Depth; i++) begin
        pst_q[i] <= pst_q[i-1];
        pch_q[i] <= pch_q[i-1];
        ppx_q[i] <= ppx_q[i-1];
        ppy_q[i] <= ppy_q[i-1];
        psx_q[i] <= psx_q[i-1];
        psy_q[i] <= psy_q[i-1];
      end
    end
  end

  // Output register: apply offsets
  logic signed [DirBits:0] cx_w, cy_w, bx, by, ox, oy;
  wsc_out_t                out_d, out_q;
  logic                    out_valid_q;

  always_comb begin
    bx = {{2{ppx_q[Depth-1][CoordBits-1]}}, ppx_q[Depth-1]};
    by = {{2{ppy_q[Depth-1][CoordBits-1]}}, ppy_q[Depth-1]};
    ox = {1'b0, offx};
    oy = {1'b0, offy};
    cx_w = psx_q[Depth-1] ? bx - ox : bx + ox;
    cy_w = psy_q[Depth-1] ? by - oy : by + oy;
    out_d.status         = pst_q[Depth-1];
    out_d.tested_channel = pch_q[Depth-1];
    if (pst_q[Depth-1] == ST_CROSS) begin
      out_d.cross_x = cx_w[CoordBits-1:0];
      out_d.cross_y = cy_w[CoordBits-1:0];
    end else begin
      out_d.cross_x = '0;
      out_d.cross_y = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pv_q[Depth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_zero_unless_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ST_CROSS |-> out_o.cross_x == '0 && out_o.cross_y == '0)
    else $error("crossing point set on a non-crossing result");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input held off without an output stall");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !in_i.mode |=> !v1_q)
    else $error("load transaction entered the test pipeline");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the wire segment crossing block.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import wsc_pkg::*;

  localparam int Latency = 4 + CoordBits + 1 + 1;
  localparam int CycleLimit = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  wsc_in_t in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  wsc_out_t out_o;
  logic cfg_we_i = 1'b0;
  logic [LimitBits-1:0] cfg_data_i = '0;

  wire_segment_crossing u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_i(in_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_o(out_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state
  logic [LimitBits-1:0] par_limit = LimitReset;
  logic [ChanBits-1:0] ref_chan = '0;
  logic [TpcBits-1:0] ref_tpc = '0;
  logic [PlaneBits-1:0] ref_plane = '0;
  logic signed [63:0] ref_px = 0, ref_py = 0, ref_rx = 0, ref_ry = 0;

  wsc_in_t pending_items[$];
  wsc_out_t crossing_results[$];
  int fail_count = 0;
  int cycle_count = 0;
  int tests_seen = 0, loads_seen = 0;
  int status_hist[6];
  bit hold_off = 1'b0;
  bit idle_on = 1'b1;
  int in_gap = 0, out_gap = 0;

  function automatic void enqueue(wsc_in_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic logic signed [63:0] round_offset(logic signed [127:0] num,
                                                     logic signed [63:0] dir,
                                                     logic signed [127:0] det);
    logic signed [127:0] n;
    logic signed [127:0] q;
    logic signed [127:0] r;
    n = num * (dir < 0 ? -dir : dir);
    q = n / det;
    r = n - q * det;
    if (2 * r >= det) q = q + 1;
    return (dir < 0) ? -q[63:0] : q[63:0];
  endfunction

  function automatic void predict_crossing(wsc_in_t it);
    logic signed [63:0] e1x, e1y, e2x, e2y, sx, sy, dx, dy;
    logic signed [127:0] det, d1, d2;
    logic signed [63:0] cx, cy;
    wsc_out_t res;
    e1x = it.end1_x; e1y = it.end1_y; e2x = it.end2_x; e2y = it.end2_y;
    if (it.mode == 1'b0) begin
      ref_chan = it.channel; ref_tpc = it.tpc; ref_plane = it.plane;
      ref_px = e1x; ref_py = e1y; ref_rx = e2x - e1x; ref_ry = e2y - e1y;
      loads_seen++;
      return;
    end
    cx = 0; cy = 0;
    res.tested_channel = it.channel;
    if (it.channel == ref_chan) res.status = ST_SAME_CHAN;
    else if (it.tpc != ref_tpc) res.status = ST_OTHER_TPC;
    else if (it.plane == ref_plane) res.status = ST_SAME_PLANE;
    else begin
      sx = e2x - e1x; sy = e2y - e1y; dx = e1x - ref_px; dy = e1y - ref_py;
      det = 128'(ref_rx) * sy - 128'(ref_ry) * sx;
      d1 = 128'(dx) * sy - 128'(dy) * sx;
      d2 = 128'(dx) * ref_ry - 128'(dy) * ref_rx;
      if (det < 0) begin
        det = -det; d1 = -d1; d2 = -d2;
      end
      if (det == 0 || det < $signed({104'd0, par_limit})) res.status = ST_PARALLEL;
      else if (d1 < 0 || d1 > det || d2 < 0 || d2 > det) res.status = ST_OUTSIDE;
      else begin
        res.status = ST_CROSS;
        cx = ref_px + round_offset(d1, ref_rx, det);
        cy = ref_py + round_offset(d1, ref_ry, det);
      end
    end
    res.cross_x = cx[CoordBits-1:0];
    res.cross_y = cy[CoordBits-1:0];
    status_hist[res.status]++;
    tests_seen++;
    crossing_results = {crossing_results, res};
  endfunction

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) predict_crossing(in_i);
      if (in_valid_i && !in_ready_o) begin
        // hold until accepted
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!hold_off && pending_items.size() > 0 &&
                   (!idle_on || $urandom_range(0, 9) != 0)) begin
        in_i <= pending_items.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
        if (idle_on && pending_items.size() > 0 && !hold_off) in_gap <= $urandom_range(1, 14);
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    wsc_out_t exp_res;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (out_valid_o && out_ready_i) begin
        if (crossing_results.size() == 0) begin
          $error("result with no expectation: status %0d", out_o.status);
          fail_count++;
        end else begin
          exp_res = crossing_results.pop_front();
          if (out_o.status !== exp_res.status) begin
            $error("status: expected %0d actual %0d", exp_res.status, out_o.status);
            fail_count++;
          end
          if (out_o.tested_channel !== exp_res.tested_channel) begin
            $error("tested_channel: expected %0d actual %0d",
                   exp_res.tested_channel, out_o.tested_channel);
            fail_count++;
          end
          if (out_o.cross_x !== exp_res.cross_x) begin
            $error("cross_x: expected %0d actual %0d", exp_res.cross_x, out_o.cross_x);
            fail_count++;
          end
          if (out_o.cross_y !== exp_res.cross_y) begin
            $error("cross_y: expected %0d actual %0d", exp_res.cross_y, out_o.cross_y);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_gap <= $urandom_range(1, 14);
        out_ready_i <= 1'b0;
      end else out_ready_i <= 1'b1;
      if (cycle_count > CycleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic wsc_in_t make_item(bit mode, logic [ChanBits-1:0] ch,
                                        logic [TpcBits-1:0] tpc, logic [PlaneBits-1:0] pl,
                                        int x1, int y1, int x2, int y2);
    wsc_in_t it;
    it.mode = mode; it.channel = ch; it.tpc = tpc; it.plane = pl;
    it.end1_x = x1[CoordBits-1:0]; it.end1_y = y1[CoordBits-1:0];
    it.end2_x = x2[CoordBits-1:0]; it.end2_y = y2[CoordBits-1:0];
    return it;
  endfunction

  function automatic int rand_coord(int span);
    if (span == 0) return int'($urandom) <<< 8 >>> 8;
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Random wire pair: load a reference, then one to eight items aimed at it, mostly tests
  task automatic queue_random_group();
    int span, n, cx0, cy0;
    logic [TpcBits-1:0] tpc;
    logic [PlaneBits-1:0] pl;
    logic [ChanBits-1:0] ch;
    span = ($urandom_range(0, 9) == 0) ? 0 : (1 << $urandom_range(4, 22));
    tpc = ($urandom_range(0, 1)) ? 8'($urandom) : 8'($urandom_range(0, 1));
    pl = 2'($urandom);
    ch = 20'($urandom);
    enqueue(make_item(1'b0, ch, tpc, pl, rand_coord(span), rand_coord(span),
                      rand_coord(span), rand_coord(span)));
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      wsc_in_t it;
      cx0 = rand_coord(span); cy0 = rand_coord(span);
      it = make_item(1'b1, ($urandom_range(0, 15) == 0) ? ch : 20'($urandom),
                     ($urandom_range(0, 7) == 0) ? 8'($urandom) : tpc,
                     ($urandom_range(0, 5) == 0) ? pl : pl + 2'($urandom_range(1, 3)),
                     cx0, cy0, rand_coord(span), rand_coord(span));
      if ($urandom_range(0, 9) == 0) it.mode = 1'b0;
      enqueue(it);
    end
  endtask

  // Sample at the falling edge so the driver's updates have settled
  task automatic drain();
    while (pending_items.size() > 0 || in_valid_i || crossing_results.size() > 0)
      @(negedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LimitBits-1:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    par_limit = v;
  endtask

  initial begin
    logic [LimitBits-1:0] limits[4];
    limits = '{24'd0, 24'd7, 24'hFFFFFF, 24'd300000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Test before any load, then the directed set
    enqueue(make_item(1'b1, 20'd5, 8'd0, 2'd1, 0, 0, 256, 256));
    enqueue(make_item(1'b0, 20'd10, 8'd3, 2'd0, -512, 0, 512, 0));
    enqueue(make_item(1'b1, 20'd10, 8'd3, 2'd1, 0, -512, 0, 512));
    enqueue(make_item(1'b1, 20'd11, 8'd4, 2'd1, 0, -512, 0, 512));
    enqueue(make_item(1'b1, 20'd11, 8'd3, 2'd0, 0, -512, 0, 512));
    enqueue(make_item(1'b1, 20'd11, 8'd3, 2'd1, 0, -512, 0, 512));
    enqueue(make_item(1'b1, 20'd12, 8'd3, 2'd2, -512, 5, 512, 5));
    enqueue(make_item(1'b1, 20'd13, 8'd3, 2'd1, -512, -1, -511, 2));
    enqueue(make_item(1'b1, 20'd14, 8'd3, 2'd3, 600, -512, 600, 512));
    enqueue(make_item(1'b1, 20'd15, 8'd3, 2'd1, 512, -512, 512, 512));
    enqueue(make_item(1'b1, 20'd16, 8'd3, 2'd1, 1, -3, -2, 3));
    enqueue(make_item(1'b0, 20'hFFFFF, 8'hFF, 2'd3,
                      -8388608, -8388608, 8388607, 8388607));
    enqueue(make_item(1'b1, 20'd0, 8'hFF, 2'd0,
                      -8388608, 8388607, 8388607, -8388608));
    enqueue(make_item(1'b1, 20'd1, 8'hFF, 2'd2,
                      8388607, -8388608, -8388608, 8388607));
    enqueue(make_item(1'b1, 20'hFFFFE, 8'hFF, 2'd1, 0, 0, 0, 0));
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      write_limit(limits[ph]);
      while (pending_items.size() < 250) queue_random_group();
      if (ph == 3) idle_on = 1'b0;
      // sender holds with an item queued until every expected result has come
      if (ph == 1) begin
        while (pending_items.size() > 0) @(negedge clk_i);
        hold_off = 1'b1;
        enqueue(make_item(1'b1, 20'd77, 8'd0, 2'd2, 1, 1, 9, 9));
        while (in_valid_i || crossing_results.size() > 0) @(negedge clk_i);
        hold_off = 1'b0;
      end
      drain();
    end
    $display("Covered %0d tests and %0d loads over four limit settings.", tests_seen,
             loads_seen);
    $display("Status counts: cross %0d chan %0d tpc %0d plane %0d par %0d out %0d",
             status_hist[0], status_hist[1], status_hist[2], status_hist[3],
             status_hist[4], status_hist[5]);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

`default_nettype wire

/* wire_segment_crossing.f */
hw/rtl/wsc_pkg.sv
hw/rtl/wsc_div.sv
hw/rtl/wire_segment_crossing.sv
tb/tb_top.sv
